### rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define HCTC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define HCTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hctc_pkg.sv
// Types, constants and helper functions of the Huffman code table codec
package hctc_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_W       = 32;
    localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int LEN_W        = 6;
    localparam int SYM_W        = 8;
    localparam int TABLE_DEPTH  = 256;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ENCODE  = 2'd1,
        CMD_DECODE  = 2'd2,
        CMD_RESTART = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        KIND_CODE   = 2'd0,
        KIND_SYMBOL = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENCODE,
        ST_SCAN
    } back_state_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  load_length;
        logic [CODE_W-1:0] load_code;
        logic              coded_bit;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SYM_W-1:0]  out_symbol;
        logic [CODE_W-1:0] out_code;
        logic [LEN_W-1:0]  out_length;
    } out_word_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    typedef struct packed {
        command_t          op;
        logic [SYM_W-1:0]  symbol;
        entry_t            entry;
        logic              coded_bit;
    } job_t;

    function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] m;
        if (len >= LEN_W'(CODE_W))
            m = '1;
        else
            m = (CODE_W'(1) << len) - CODE_W'(1);
        return m;
    endfunction

endpackage

### rtl/hctc_ram.sv
// Generic single-write, single-read RAM with registered read data
module hctc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/hctc_front.sv
// Front end: accepts input words, classifies them into jobs and queues them
module hctc_front import hctc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_data,
    output logic     job_valid,
    output job_t     job,
    input  logic     job_pop
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    job_t              job_in;
    logic [LEN_W-1:0]  clamped_len;
    logic              push;
    logic              pop;

    always_comb
    begin
        clamped_len = (in_data.load_length > LEN_W'(LEN_CAP)) ? '0 : in_data.load_length;
        job_in.op         = command_t'(in_data.command);
        job_in.symbol     = in_data.symbol;
        job_in.entry.len  = clamped_len;
        job_in.entry.code = in_data.load_code & low_mask(clamped_len);
        job_in.coded_bit  = in_data.coded_bit;
    end

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_pop && job_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= job_in;
    end

endmodule

### rtl/hctc_back.sv
// Back end: code table, encode lookup, bitwise decode scan and result register
module hctc_back import hctc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  job_t      job,
    output logic      job_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    back_state_t       state_reg, state_next;
    logic [CODE_W-1:0] acc_reg, acc_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic              valid_q_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    entry_t            ram_rdata;
    logic [LEN_W-1:0]  cnt_inc;
    logic              hit;

    hctc_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cnt_inc = cnt_reg + 1'b1;
    assign hit     = valid_q_reg && (ram_rdata.len == cnt_reg) && (ram_rdata.code == acc_reg);

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        sym_next       = sym_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        job_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = job.symbol;
        ram_wdata      = job.entry;
        ram_raddr      = idx_reg + 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && !out_valid_reg)
                begin
                    job_pop = 1'b1;
                    unique case (job.op)
                        CMD_LOAD:
                        begin
                            ram_we = 1'b1;
                        end
                        CMD_ENCODE:
                        begin
                            ram_raddr  = job.symbol;
                            sym_next   = job.symbol;
                            state_next = ST_ENCODE;
                        end
                        CMD_DECODE:
                        begin
                            cnt_next   = cnt_inc;
                            acc_next   = {acc_reg[CODE_W-2:0], job.coded_bit} & low_mask(cnt_inc);
                            ram_raddr  = '0;
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                        CMD_RESTART:
                        begin
                            acc_next = '0;
                            cnt_next = '0;
                        end
                    endcase
                end
            end
            ST_ENCODE:
            begin
                out_valid_next           = 1'b1;
                out_word_next.kind       = KIND_CODE;
                out_word_next.out_symbol = sym_reg;
                out_word_next.out_code   = valid_q_reg ? ram_rdata.code : '0;
                out_word_next.out_length = valid_q_reg ? ram_rdata.len : '0;
                state_next               = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    out_valid_next           = 1'b1;
                    out_word_next.kind       = KIND_SYMBOL;
                    out_word_next.out_symbol = idx_reg;
                    out_word_next.out_code   = acc_reg;
                    out_word_next.out_length = cnt_reg;
                    acc_next                 = '0;
                    cnt_next                 = '0;
                    state_next               = ST_IDLE;
                end
                else if (idx_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    if (cnt_reg >= LEN_W'(LEN_CAP))
                    begin
                        out_valid_next           = 1'b1;
                        out_word_next.kind       = KIND_ERROR;
                        out_word_next.out_symbol = '0;
                        out_word_next.out_code   = acc_reg;
                        out_word_next.out_length = cnt_reg;
                        acc_next                 = '0;
                        cnt_next                 = '0;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
                valid_reg[ram_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        sym_reg      <= sym_next;
        out_word_reg <= out_word_next;
        valid_q_reg  <= valid_reg[ram_raddr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

### rtl/huffman_code_table_codec_core.sv
// Top level of the Huffman code table codec
// A two-word queue decouples input from the execution engine, which owns a 256-entry
// code table in one single-port-read memory and a one-word result register. A load or
// restart word is done in the idle state, and an encode word adds the encode state. A
// decode-bit word walks the table one entry per cycle with a single comparator and stops
// early at the first (lowest symbol) match. Table entries carry per-entry valid flops
// cleared by reset, so no clearing pass is needed and the block is ready right after
// reset. New words are accepted while a result waits to be taken.
module huffman_code_table_codec_core import hctc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic job_valid;
    job_t job;
    logic job_pop;

    hctc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    hctc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### rtl/hctc_checker.sv
// Port-level assertions for the Huffman code table codec, bound to the top level
`include "assert_macros.svh"

module hctc_checker import hctc_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    `HCTC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")
    `HCTC_ASSERT_SAME(a_err_full, clk, rst_n, out_valid && (out_data.kind == KIND_ERROR), (out_data.out_length == LEN_W'(LEN_CAP)) && (out_data.out_symbol == '0), "decode error before length limit")
    `HCTC_ASSERT_SAME(a_sym_len, clk, rst_n, out_valid && (out_data.kind == KIND_SYMBOL), (out_data.out_length != '0) && (out_data.out_length <= LEN_W'(LEN_CAP)), "decoded symbol with bad length")
    `HCTC_ASSERT_SAME(a_enc_len, clk, rst_n, out_valid && (out_data.kind == KIND_CODE), out_data.out_length <= LEN_W'(LEN_CAP), "encoded length above limit")

endmodule

bind huffman_code_table_codec_core hctc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Huffman code table codec core
module testbench;
    import hctc_pkg::*;

    localparam int ITEM_TARGET  = 950;
    localparam int DRAIN_CYCLES = 600;
    localparam int STALL_AT     = 60;
    localparam int STALL_CYCLES = 3000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;

    logic [LEN_W-1:0]  len_tbl  [TABLE_DEPTH];
    logic [CODE_W-1:0] code_tbl [TABLE_DEPTH];
    logic [CODE_W-1:0] acc_bits;
    logic [LEN_W-1:0]  acc_count;

    in_word_t  stim_words[$];
    out_word_t expected_words[$];
    bit        live[TABLE_DEPTH];

    int total_words;
    int words_in     = 0;
    int results_seen = 0;
    int errors       = 0;
    int n_codes      = 0;
    int n_symbols    = 0;
    int n_faults     = 0;
    int n_phases     = 0;
    int send_wait    = 0;
    int recv_wait    = 0;
    int stall_left   = 0;
    bit send_burst   = 1'b0;
    bit recv_burst   = 1'b0;
    bit stall_done   = 1'b0;

    huffman_code_table_codec_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CODE_W-1:0] mask_of(input logic [LEN_W-1:0] len);
        logic [CODE_W:0] m;
        m = ((CODE_W+1)'(1) << len) - (CODE_W+1)'(1);
        return m[CODE_W-1:0];
    endfunction

    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 10));
    endfunction

    task automatic push_word(input command_t cmd, input logic [SYM_W-1:0] sym,
                             input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code,
                             input logic bit_in);
        in_word_t w;
        w.command     = cmd;
        w.symbol      = sym;
        w.load_length = len;
        w.load_code   = code;
        w.coded_bit   = bit_in;
        if (cmd == CMD_LOAD)
            live[sym] = (len != '0 && len <= LEN_W'(LEN_CAP));
        stim_words = {stim_words, w};
    endtask

    task automatic push_load(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                             input logic [CODE_W-1:0] code);
        push_word(CMD_LOAD, sym, len, code, 1'($urandom));
    endtask

    task automatic push_encode(input logic [SYM_W-1:0] sym);
        push_word(CMD_ENCODE, sym, LEN_W'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic push_decode(input logic b);
        push_word(CMD_DECODE, SYM_W'($urandom), LEN_W'($urandom), $urandom, b);
    endtask

    task automatic push_restart();
        push_word(CMD_RESTART, SYM_W'($urandom), LEN_W'($urandom), $urandom, 1'($urandom));
    endtask

    // update the table and decoder state, queue the result this word causes
    task automatic apply_command(input in_word_t w);
        out_word_t        r;
        logic [LEN_W-1:0] len;
        bit               hit;
        int               s;
        r   = '0;
        hit = 1'b0;
        case (w.command)
            CMD_LOAD:
            begin
                len = (w.load_length > LEN_W'(LEN_CAP)) ? LEN_W'(0) : w.load_length;
                len_tbl[w.symbol]  = len;
                code_tbl[w.symbol] = w.load_code & mask_of(len);
            end
            CMD_ENCODE:
            begin
                r.kind       = KIND_CODE;
                r.out_symbol = w.symbol;
                r.out_code   = code_tbl[w.symbol];
                r.out_length = len_tbl[w.symbol];
                expected_words = {expected_words, r};
            end
            CMD_DECODE:
            begin
                acc_count = acc_count + 1'b1;
                acc_bits  = ((acc_bits << 1) | CODE_W'(w.coded_bit)) & mask_of(acc_count);
                for (s = 0; s < TABLE_DEPTH && !hit; s++)
                begin
                    if (len_tbl[s] != '0 && len_tbl[s] == acc_count && code_tbl[s] == acc_bits)
                    begin
                        hit          = 1'b1;
                        r.kind       = KIND_SYMBOL;
                        r.out_symbol = SYM_W'(s);
                    end
                end
                if (hit || acc_count >= LEN_W'(LEN_CAP))
                begin
                    if (!hit)
                        r.kind = KIND_ERROR;
                    r.out_code   = acc_bits;
                    r.out_length = acc_count;
                    expected_words = {expected_words, r};
                    acc_bits  = '0;
                    acc_count = '0;
                end
            end
            default:
            begin
                acc_bits  = '0;
                acc_count = '0;
            end
        endcase
    endtask

    task automatic check_result(input out_word_t got);
        out_word_t want;
        if (expected_words.size() == 0)
        begin
            errors++;
            $display("%0t: expected no word, actual kind=%0d sym=%0d code=%h len=%0d",
                     $time, got.kind, got.out_symbol, got.out_code, got.out_length);
        end
        else
        begin
            want = expected_words.pop_front();
            case (got.kind)
                KIND_CODE:   n_codes++;
                KIND_SYMBOL: n_symbols++;
                default:     n_faults++;
            endcase
            if (got.kind !== want.kind || got.out_symbol !== want.out_symbol ||
                got.out_code !== want.out_code || got.out_length !== want.out_length)
            begin
                errors++;
                $display("%0t: expected kind=%0d sym=%0d code=%h len=%0d, %s",
                         $time, want.kind, want.out_symbol, want.out_code, want.out_length,
                         $sformatf("actual kind=%0d sym=%0d code=%h len=%0d",
                                   got.kind, got.out_symbol, got.out_code, got.out_length));
            end
        end
    endtask

    // driver: offer queued words, predict each one as it is accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                apply_command(in_data);
                words_in <= words_in + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait = send_wait - 1;
                    in_valid <= 1'b0;
                end
                else if (stim_words.size() > 0)
                begin
                    in_data   <= stim_words.pop_front();
                    in_valid  <= 1'b1;
                    send_wait = draw_wait(send_burst);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: take result words and compare against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_result(out_data);
                results_seen <= results_seen + 1;
                recv_wait = draw_wait(recv_burst);
            end
            if (stall_left > 0)
                out_ready <= 1'b0;
            else if (recv_wait > 0)
            begin
                recv_wait = recv_wait - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // hold off the output once for a long stretch so the input backs up
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (!stall_done && results_seen >= STALL_AT)
        begin
            stall_left <= STALL_CYCLES;
            stall_done <= 1'b1;
        end
    end

    initial
    begin
        #15_000_000;
        $display("[huffman_code_table_codec_core] ERROR");
        $finish;
    end

    initial
    begin
        logic [CODE_W-1:0] leaf_code[$];
        int                leaf_len[$];
        logic [SYM_W-1:0]  leaf_sym[$];
        bit                taken[TABLE_DEPTH];
        logic [CODE_W-1:0] c;
        int                k;
        int                p;
        int                b;
        int                s;
        int                n_leaf;
        int                max_len;
        int                n_sym;
        int                hole;
        int                tries;
        bit                skew;

        foreach (len_tbl[i])
        begin
            len_tbl[i]  = '0;
            code_tbl[i] = '0;
            live[i]     = 1'b0;
        end
        acc_bits  = '0;
        acc_count = '0;

        // extremes, absent and oversize loads, duplicate codes, padding and restart
        push_encode(8'd0);
        push_encode(8'd255);
        push_load(8'd0, 6'd1, 32'hFFFF_FFFF);
        push_load(8'd255, 6'd32, 32'hFFFF_FFFF);
        push_load(8'd128, 6'd33, 32'h1234_5678);
        push_load(8'd64, 6'd63, 32'hFFFF_FFFF);
        push_encode(8'd0);
        push_encode(8'd255);
        push_encode(8'd128);
        push_encode(8'd64);
        push_load(8'd9, 6'd2, 32'hFFFF_FFFC);
        push_load(8'd3, 6'd2, 32'h0000_0000);
        push_decode(1'b1);
        push_decode(1'b0);
        push_decode(1'b0);
        push_decode(1'b0);
        push_restart();
        push_decode(1'b0);
        push_decode(1'b1);
        push_restart();
        push_load(8'd0, 6'd0, 32'hFFFF_FFFF);
        push_encode(8'd0);
        push_decode(1'b1);
        push_restart();

        while (stim_words.size() < ITEM_TARGET)
        begin
            for (s = 0; s < TABLE_DEPTH; s++)
            begin
                if (live[s])
                    push_load(SYM_W'(s),
                              $urandom_range(0, 1) ? LEN_W'(0) : LEN_W'($urandom_range(33, 63)),
                              $urandom);
            end
            push_restart();

            // grow a prefix code by splitting leaves; the deep set is a chain to 32 bits
            skew    = (n_phases % 4 == 1);
            max_len = skew ? LEN_CAP : int'($urandom_range(2, 12));
            n_leaf  = skew ? LEN_CAP + 1 : int'($urandom_range(2, 24));
            leaf_code.delete();
            leaf_len.delete();
            leaf_code = {leaf_code, CODE_W'(0)};
            leaf_len  = {leaf_len, int'(0)};
            tries = 0;
            while (leaf_code.size() < n_leaf && tries < 200)
            begin
                k = skew ? leaf_code.size() - 1 : int'($urandom_range(0, leaf_code.size() - 1));
                if (leaf_len[k] < max_len)
                begin
                    c            = leaf_code[k];
                    leaf_code[k] = c << 1;
                    leaf_len[k]  = leaf_len[k] + 1;
                    leaf_code    = {leaf_code, (c << 1) | CODE_W'(1)};
                    leaf_len     = {leaf_len, leaf_len[k]};
                end
                tries++;
            end

            foreach (taken[i])
                taken[i] = 1'b0;
            leaf_sym.delete();
            for (k = 0; k < leaf_code.size(); k++)
            begin
                do
                    s = $urandom_range(0, TABLE_DEPTH - 1);
                while (taken[s]);
                taken[s] = 1'b1;
                leaf_sym = {leaf_sym, SYM_W'(s)};
            end

            // leave one code out now and then so the stream hits a dead prefix
            if (skew)
                hole = 0;
            else if ($urandom_range(0, 2) == 0)
                hole = $urandom_range(0, leaf_code.size() - 1);
            else
                hole = -1;
            for (k = 0; k < leaf_code.size(); k++)
            begin
                if (k != hole)
                    push_load(leaf_sym[k], LEN_W'(leaf_len[k]),
                              ($urandom & ~mask_of(LEN_W'(leaf_len[k]))) | leaf_code[k]);
            end

            if ($urandom_range(0, 3) == 0)
            begin
                k = $urandom_range(0, leaf_code.size() - 1);
                do
                    s = $urandom_range(0, TABLE_DEPTH - 1);
                while (taken[s]);
                taken[s] = 1'b1;
                push_load(SYM_W'(s), LEN_W'(leaf_len[k]), leaf_code[k]);
            end

            for (p = $urandom_range(3, 12); p > 0; p--)
                push_encode(($urandom_range(0, 3) == 0) ? SYM_W'($urandom)
                            : leaf_sym[$urandom_range(0, leaf_sym.size() - 1)]);

            n_sym = skew ? int'($urandom_range(8, 16)) : int'($urandom_range(15, 40));
            for (p = 0; p < n_sym; p++)
            begin
                k = $urandom_range(0, leaf_code.size() - 1);
                for (b = leaf_len[k] - 1; b >= 0; b--)
                    push_decode(leaf_code[k][b]);
                if ($urandom_range(0, 9) == 0)
                begin
                    for (b = $urandom_range(0, 7); b > 0; b--)
                        push_decode(1'($urandom));
                    push_restart();
                end
            end

            if (skew)
            begin
                push_restart();
                push_decode(1'b0);
                for (b = 1; b < LEN_CAP; b++)
                    push_decode(1'($urandom));
            end

            for (p = $urandom_range(0, 24); p > 0; p--)
                push_decode(1'($urandom));
            for (p = $urandom_range(2, 6); p > 0; p--)
                push_word(command_t'($urandom_range(0, 3)), SYM_W'($urandom),
                          LEN_W'($urandom), $urandom, 1'($urandom));
            n_phases++;
        end
        // trim the last code set so the run sends the planned number of words
        if (stim_words.size() > ITEM_TARGET)
            stim_words = stim_words[0:ITEM_TARGET-1];
        total_words = stim_words.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (words_in < total_words)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_words.size() != 0)
        begin
            errors = errors + expected_words.size();
            $display("%0t: %0d predicted words never arrived", $time, expected_words.size());
        end
        $display("Covered %0d input words, %0d results: %0d codes, %0d symbols, %0d bad prefixes",
                 words_in, results_seen, n_codes, n_symbols, n_faults);
        $display("Used %0d code sets including a 32-bit chain and a %0d-cycle output hold",
                 n_phases, STALL_CYCLES);
        if (errors == 0)
            $display("[huffman_code_table_codec_core] OK");
        else
            $display("[huffman_code_table_codec_core] ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/hctc_pkg.sv
rtl/hctc_ram.sv
rtl/hctc_front.sv
rtl/hctc_back.sv
rtl/huffman_code_table_codec_core.sv
rtl/hctc_checker.sv
tb/testbench.sv
